// ===== rtl/pirl_pkg.sv =====
`timescale 1ns / 1ps
// Types and codes shared by the positional insert/remove list.
// No dependencies.
package pirl_pkg;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 4;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  typedef enum logic {
    OUT_IDLE = 1'b0,
    OUT_HOLD = 1'b1
  } out_state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    do_insert;
    logic    do_remove;
    logic    give_data;
    status_e status;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_le;
    logic pos_lt;
  } stat_t;

endpackage

// ===== rtl/pirl_in_if.sv =====
`timescale 1ns / 1ps
// Command channel: valid/ready handshake with command, position and value.
// Depends on pirl_pkg.
interface pirl_in_if;
  import pirl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [POS_W-1:0]          position;
  logic signed [WORD_W-1:0]  value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

// ===== rtl/pirl_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with data, status and count.
// Depends on pirl_pkg.
interface pirl_out_if;
  import pirl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  data;
  logic [1:0]                status;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

// ===== rtl/pirl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: output-register state machine, handshake and command decode.
// Depends on pirl_pkg.
module pirl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  logic [1:0]       command,
  input  pirl_pkg::stat_t  stat,
  output logic             in_ready,
  output logic             out_valid,
  output pirl_pkg::ctrl_t  ctrl
);
  import pirl_pkg::*;

  out_state_e state, state_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OUT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = OUT_HOLD;
    end else if (out_ready) begin
      state_next = OUT_IDLE;
    end
  end

  always_comb begin
    in_ready       = !rst && ((state == OUT_IDLE) || out_ready);
    out_valid      = (state == OUT_HOLD);
    ctrl           = '0;
    ctrl.status    = STAT_OK;
    ctrl.load      = accept;
    unique case (cmd_e'(command))
      CMD_INSERT: begin
        if (stat.full) begin
          ctrl.status = STAT_FULL;
        end else if (!stat.pos_le) begin
          ctrl.status = STAT_BADPOS;
        end else begin
          ctrl.do_insert = accept;
        end
      end
      CMD_REMOVE, CMD_READ: begin
        if (stat.empty) begin
          ctrl.status = STAT_EMPTY;
        end else if (!stat.pos_lt) begin
          ctrl.status = STAT_BADPOS;
        end else begin
          ctrl.give_data = 1'b1;
          ctrl.do_remove = accept && (cmd_e'(command) == CMD_REMOVE);
        end
      end
      default: begin
        ctrl.status = STAT_BADPOS;
      end
    endcase
  end

endmodule

// ===== rtl/pirl_dp.sv =====
`timescale 1ns / 1ps
// Datapath: entry shift registers, entry count, position compares, result register.
// Depends on pirl_pkg.
module pirl_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pirl_pkg::POS_W-1:0]       position,
  input  pirl_pkg::word_t                  value,
  input  pirl_pkg::ctrl_t                  ctrl,
  output pirl_pkg::stat_t                  stat,
  output pirl_pkg::word_t                  data,
  output logic [1:0]                       status,
  output logic [pirl_pkg::COUNT_W-1:0]     count
);
  import pirl_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int OW   = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int RDN  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  word_t           entry [CAPACITY];
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_after;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pos_ext;
  logic [OW-1:0]   cnt_wide;
  word_t           rd_word;

  assign cnt_ext    = CMPW'(cnt);
  assign pos_ext    = CMPW'(position);
  assign stat.full  = (cnt == CW'(CAPACITY));
  assign stat.empty = (cnt == '0);
  assign stat.pos_le = (pos_ext <= cnt_ext);
  assign stat.pos_lt = (pos_ext < cnt_ext);

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < RDN; k++) begin
      if (position == POS_W'(k)) begin
        rd_word = entry[k];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
    localparam logic [CMPW-1:0] GIDX = CMPW'(g);
    word_t from_below;
    word_t from_above;

    if (g == 0) begin : g_first
      assign from_below = value;
    end else begin : g_mid
      assign from_below = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign from_above = entry[g];
    end else begin : g_notlast
      assign from_above = entry[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctrl.do_insert) begin
        if (pos_ext == GIDX) begin
          entry[g] <= value;
        end else if (pos_ext < GIDX) begin
          entry[g] <= from_below;
        end
      end else if (ctrl.do_remove && (pos_ext <= GIDX)) begin
        entry[g] <= from_above;
      end
    end
  end

  always_comb begin
    priority if (ctrl.do_insert) begin
      cnt_after = cnt + CW'(1);
    end else if (ctrl.do_remove) begin
      cnt_after = cnt - CW'(1);
    end else begin
      cnt_after = cnt;
    end
  end

  assign cnt_wide = OW'(cnt_after);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_after;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data   <= ctrl.give_data ? rd_word : '0;
      status <= ctrl.status;
      count  <= cnt_wide[COUNT_W-1:0];
    end
  end

endmodule

// ===== rtl/positional_insert_remove_list.sv =====
`timescale 1ns / 1ps
// Positional insert/remove list of up to CAPACITY signed 32-bit words.
// The result is registered and valid in the cycle after the command transfer.
// Throughput: one command per cycle while rsp.ready takes the result; entries at and above position shift together.
// Reset (rst, synchronous): count cleared, no result held (rsp.valid low); entries and result data undefined.
// Depends on pirl_pkg, pirl_in_if, pirl_out_if, pirl_ctrl, pirl_dp.
module positional_insert_remove_list #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  pirl_in_if.sink    req,
  pirl_out_if.source rsp
);
  import pirl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  pirl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .command   (req.command),
    .stat      (stat),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .ctrl      (ctrl)
  );

  pirl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .position (req.position),
    .value    (req.value),
    .ctrl     (ctrl),
    .stat     (stat),
    .data     (rsp.data),
    .status   (rsp.status),
    .count    (rsp.count)
  );

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != STAT_OK)) |-> (rsp.data == '0))
    else $error("nonzero data on error status");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !(rsp.valid && !rsp.ready))
    else $error("transfer accepted while result stalled");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> rsp.valid)
    else $error("no result after transfer");

endmodule
